### src/hhq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Heightmap height query package
// Shared types and constants for the heightmap height query block.
// ============================================================================
package hhq_pkg;

    localparam int unsigned DIM_W    = 9;
    localparam int unsigned IDX_W    = 16;
    localparam int unsigned HGT_W    = 16;
    localparam int unsigned CRD_W    = 20;
    localparam int unsigned FB_W     = 5;
    localparam int unsigned WGT_W    = 17;
    localparam int unsigned CS_W     = 26;
    localparam int unsigned PROD_W   = 35;
    localparam int unsigned NUM_W    = 37;
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [DIM_W-1:0] GRID_DIM_MAX = 9'd256;
    localparam logic [FB_W-1:0]  FB_BASE      = 5'd9;

    localparam logic [1:0] REG_GRID_COLUMNS      = 2'd0;
    localparam logic [1:0] REG_GRID_ROWS         = 2'd1;
    localparam logic [1:0] REG_CELL_SPACING_LOG2 = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] grid_columns;
        logic [DIM_W-1:0] grid_rows;
        logic [2:0]       cell_spacing_log2;
    } t_cfg;

    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        entry_index;
        logic signed [HGT_W-1:0] entry_height;
        logic signed [CRD_W-1:0] query_x;
        logic signed [CRD_W-1:0] query_z;
    } t_in_item;

    typedef struct packed {
        logic signed [HGT_W-1:0] height_out;
        logic                    outside_grid;
    } t_out_item;

    typedef struct packed {
        logic signed [HGT_W-1:0] a;
        logic signed [HGT_W-1:0] b;
        logic signed [HGT_W-1:0] c;
        logic signed [HGT_W-1:0] d;
        logic [WGT_W-1:0]        s;
        logic [WGT_W-1:0]        t;
        logic [FB_W-1:0]         fb;
    } t_interp_req;

endpackage

### src/hhq_cfg.sv
`timescale 1ns / 1ps
// ============================================================================
// Heightmap configuration registers
// APB register file holding the grid size and the cell spacing.
// ============================================================================
module hhq_cfg import hhq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_columns      <= 9'd256;
            r_cfg.grid_rows         <= 9'd256;
            r_cfg.cell_spacing_log2 <= 3'd0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_GRID_COLUMNS:      r_cfg.grid_columns      <= pwdata[DIM_W-1:0];
                REG_GRID_ROWS:         r_cfg.grid_rows         <= pwdata[DIM_W-1:0];
                REG_CELL_SPACING_LOG2: r_cfg.cell_spacing_log2 <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_GRID_COLUMNS:      prdata = PDATA_W'(r_cfg.grid_columns);
            REG_GRID_ROWS:         prdata = PDATA_W'(r_cfg.grid_rows);
            REG_CELL_SPACING_LOG2: prdata = PDATA_W'(r_cfg.cell_spacing_log2);
            default:               prdata = '0;
        endcase
    end

endmodule

### src/hhq_store.sv
`timescale 1ns / 1ps
// ============================================================================
// Heightmap store
// Single-port-write, single-port-read height memory with registered read data.
// ============================================================================
module hhq_store import hhq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [HGT_W-1:0] i_wr_data,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [HGT_W-1:0] o_rd_data
);

    logic [HGT_W-1:0] mem [2**IDX_W];
    logic [HGT_W-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

endmodule

### src/hhq_interp.sv
`timescale 1ns / 1ps
// ============================================================================
// Heightmap triangle interpolator
// Two-stage datapath: triangle select and weighted products, then sum,
// round to nearest and saturate.
// ============================================================================
module hhq_interp import hhq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  t_interp_req             i_req,
    output logic                    o_done,
    output logic signed [HGT_W-1:0] o_height
);

    logic [WGT_W-1:0]         one;
    logic                     upper;
    logic signed [HGT_W-1:0]  h0;
    logic signed [HGT_W-1:0]  h1;
    logic signed [HGT_W-1:0]  h2;
    logic [WGT_W-1:0]         w1;
    logic [WGT_W-1:0]         w2;
    logic signed [HGT_W:0]    d1;
    logic signed [HGT_W:0]    d2;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;

    logic                     r_v1;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic signed [HGT_W-1:0]  r_h0;
    logic [FB_W-1:0]          r_fb;

    logic [WGT_W-1:0]         one2;
    logic signed [NUM_W-1:0]  half;
    logic signed [NUM_W-1:0]  num;
    logic signed [NUM_W-1:0]  rnd;
    logic signed [HGT_W-1:0]  sat;

    logic                     r_done;
    logic signed [HGT_W-1:0]  r_height;

    always_comb begin
        one   = WGT_W'(1) << i_req.fb;
        upper = ({1'b0, i_req.s} + {1'b0, i_req.t}) <= {1'b0, one};
        if (upper) begin
            h0 = i_req.a;
            h1 = i_req.b;
            h2 = i_req.c;
            w1 = i_req.s;
            w2 = i_req.t;
        end else begin
            h0 = i_req.d;
            h1 = i_req.c;
            h2 = i_req.b;
            w1 = one - i_req.s;
            w2 = one - i_req.t;
        end
        d1 = {h1[HGT_W-1], h1} - {h0[HGT_W-1], h0};
        d2 = {h2[HGT_W-1], h2} - {h0[HGT_W-1], h0};
        p1 = $signed({1'b0, w1}) * d1;
        p2 = $signed({1'b0, w2}) * d2;
    end

    always_comb begin
        one2 = WGT_W'(1) << r_fb;
        half = $signed(NUM_W'(one2 >> 1));
        num  = (NUM_W'(r_h0) <<< r_fb) + NUM_W'(r_p1) + NUM_W'(r_p2) + half;
        rnd  = num >>> r_fb;
        if (rnd > NUM_W'(32767)) begin
            sat = 16'sh7FFF;
        end else if (rnd < -NUM_W'(32768)) begin
            sat = -16'sh8000;
        end else begin
            sat = rnd[HGT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_done <= r_v1;
        end
        r_p1     <= p1;
        r_p2     <= p2;
        r_h0     <= h0;
        r_fb     <= i_req.fb;
        r_height <= sat;
    end

    assign o_done   = r_done;
    assign o_height = r_height;

endmodule

### src/heightmap_height_query.sv
`timescale 1ns / 1ps
// ============================================================================
// Heightmap height query
// Stores a heightmap and returns the height at a world point, interpolated
// on one triangle of the cell that contains it.
//
//   Channel   Handshake                 Payload
//   in        i_in_valid / o_in_ready   i_in_item  (t_in_item)
//   out       o_out_valid / i_out_ready o_out_item (t_out_item)
//   cfg       APB psel/penable/pwrite   paddr, pwdata, prdata
//
// A query passes the states map, cell, index, read, calc, wait and finish;
// a write or an outside point goes from map to finish. Items are taken only
// in idle. The four corner heights are read one per cycle through the single
// read port. Reset clears the sequencer and the output register; the store
// is not cleared. A result waiting at the output holds the next one back.
// ============================================================================
module heightmap_height_query import hhq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_CELL,
        S_IDX,
        S_READ,
        S_CALC,
        S_WAIT,
        S_FIN
    } t_state;

    t_cfg        cfg;
    t_state      r_state;
    t_in_item    r_req;
    t_out_item   r_res;
    t_out_item   r_out_item;
    logic        r_out_valid;

    logic signed [CS_W-1:0] r_cs;
    logic signed [CS_W-1:0] r_ds;
    logic [7:0]             r_col;
    logic [7:0]             r_row;
    logic [WGT_W-1:0]       r_s;
    logic [WGT_W-1:0]       r_t;
    logic [IDX_W-1:0]       r_base;
    logic [2:0]             r_rd_cnt;
    logic signed [HGT_W-1:0] r_corner [4];

    logic [DIM_W-1:0]       cols_c;
    logic [DIM_W-1:0]       rows_c;
    logic [DIM_W-1:0]       cols_m1;
    logic [DIM_W-1:0]       rows_m1;
    logic [FB_W-1:0]        fb;
    logic signed [CS_W-1:0] cs;
    logic signed [CS_W-1:0] ds;
    logic signed [CS_W-1:0] lim_c;
    logic signed [CS_W-1:0] lim_r;
    logic                   outside;
    logic [CS_W-1:0]        col_full;
    logic [CS_W-1:0]        row_full;
    logic [7:0]             col_sel;
    logic [7:0]             row_sel;
    logic [CS_W-1:0]        s_full;
    logic [CS_W-1:0]        t_full;
    logic [IDX_W:0]         base_full;
    logic [IDX_W-1:0]       rd_off;
    logic [IDX_W-1:0]       rd_addr;
    logic [HGT_W-1:0]       rd_data;
    logic                   wr_en;
    t_interp_req            ireq;
    logic                   i_done;
    logic signed [HGT_W-1:0] i_height;

    hhq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    hhq_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_req.entry_index),
        .i_wr_data (r_req.entry_height),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    hhq_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_CALC),
        .i_req    (ireq),
        .o_done   (i_done),
        .o_height (i_height)
    );

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign wr_en       = (r_state == S_MAP) && (r_req.req_type == REQ_WRITE);

    always_comb begin
        cols_c  = (cfg.grid_columns > GRID_DIM_MAX) ? GRID_DIM_MAX : cfg.grid_columns;
        rows_c  = (cfg.grid_rows > GRID_DIM_MAX) ? GRID_DIM_MAX : cfg.grid_rows;
        cols_m1 = cols_c - 9'd1;
        rows_m1 = rows_c - 9'd1;
        fb      = FB_BASE + FB_W'(cfg.cell_spacing_log2);

        cs    = (CS_W'(r_req.query_x) <<< 1) + $signed(CS_W'(cols_m1) << (fb - 5'd1));
        ds    = $signed(CS_W'(rows_m1) << (fb - 5'd1)) - (CS_W'(r_req.query_z) <<< 1);
        lim_c = $signed(CS_W'(cols_m1) << fb);
        lim_r = $signed(CS_W'(rows_m1) << fb);
        outside = (cols_c < 9'd2) || (rows_c < 9'd2) || (cs < 0) || (cs > lim_c)
                  || (ds < 0) || (ds > lim_r);

        col_full = CS_W'(r_cs) >> fb;
        row_full = CS_W'(r_ds) >> fb;
        col_sel  = (col_full > CS_W'(cols_c - 9'd2)) ? 8'(cols_c - 9'd2) : col_full[7:0];
        row_sel  = (row_full > CS_W'(rows_c - 9'd2)) ? 8'(rows_c - 9'd2) : row_full[7:0];
        s_full   = CS_W'(r_cs) - (CS_W'(col_sel) << fb);
        t_full   = CS_W'(r_ds) - (CS_W'(row_sel) << fb);

        base_full = 17'(r_row) * 17'(cols_c) + 17'(r_col);

        unique case (r_rd_cnt[1:0])
            2'd0:    rd_off = '0;
            2'd1:    rd_off = 16'd1;
            2'd2:    rd_off = IDX_W'(cols_c);
            default: rd_off = IDX_W'(cols_c) + 16'd1;
        endcase
        rd_addr = r_base + rd_off;

        ireq.a  = r_corner[0];
        ireq.b  = r_corner[1];
        ireq.c  = r_corner[2];
        ireq.d  = r_corner[3];
        ireq.s  = r_s;
        ireq.t  = r_t;
        ireq.fb = fb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_cnt    <= '0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_item;
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_cs <= cs;
                    r_ds <= ds;
                    if (r_req.req_type == REQ_WRITE) begin
                        r_res.height_out   <= '0;
                        r_res.outside_grid <= 1'b0;
                        r_state            <= S_FIN;
                    end else if (outside) begin
                        r_res.height_out   <= '0;
                        r_res.outside_grid <= 1'b1;
                        r_state            <= S_FIN;
                    end else begin
                        r_state <= S_CELL;
                    end
                end
                S_CELL: begin
                    r_col   <= col_sel;
                    r_row   <= row_sel;
                    r_s     <= s_full[WGT_W-1:0];
                    r_t     <= t_full[WGT_W-1:0];
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    r_base   <= base_full[IDX_W-1:0];
                    r_rd_cnt <= '0;
                    r_state  <= S_READ;
                end
                S_READ: begin
                    if (r_rd_cnt != 3'd0) begin
                        r_corner[2'(r_rd_cnt - 3'd1)] <= rd_data;
                    end
                    if (r_rd_cnt == 3'd4) begin
                        r_state <= S_CALC;
                    end else begin
                        r_rd_cnt <= r_rd_cnt + 3'd1;
                    end
                end
                S_CALC: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_done) begin
                        r_res.height_out   <= i_height;
                        r_res.outside_grid <= 1'b0;
                        r_state            <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_item  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### bench/heightmap_height_query_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Heightmap height query testbench
// Drives write and query items through the valid/ready input channel and
// checks every result against a local model of the heightmap store and the
// triangle interpolation. The grid registers are reprogrammed over the APB
// port between phases, and both channels idle and stall at random.
// ============================================================================
module heightmap_height_query_test;
    import hhq_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in_item;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out_item;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    heightmap_height_query uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    logic [HGT_W-1:0] height_mem [0:65535];
    bit               entry_written [0:65535];
    logic [DIM_W-1:0] cfg_columns;
    logic [DIM_W-1:0] cfg_rows;
    logic [2:0]       cfg_spacing;

    t_out_item pending_heights [$];
    int        error_count;
    int        gap_pct;
    int        stall_pct;
    int        hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned clamp_dimension(logic [DIM_W-1:0] v);
        return (v > GRID_DIM_MAX) ? int'(GRID_DIM_MAX) : int'(v);
    endfunction

    function automatic bit find_cell(input logic signed [CRD_W-1:0] x,
                                     input logic signed [CRD_W-1:0] z,
                                     output int unsigned col, output int unsigned row,
                                     output longint s, output longint t,
                                     output int unsigned fb);
        int unsigned cols;
        int unsigned rows;
        longint      cs;
        longint      ds;
        cols = clamp_dimension(cfg_columns);
        rows = clamp_dimension(cfg_rows);
        fb   = FB_BASE + cfg_spacing;
        col  = 0;
        row  = 0;
        s    = 0;
        t    = 0;
        if (cols < 2 || rows < 2) begin
            return 1'b0;
        end
        cs = 2 * longint'(x) + (longint'(cols - 1) << (fb - 1));
        ds = (longint'(rows - 1) << (fb - 1)) - 2 * longint'(z);
        if (cs < 0 || cs > (longint'(cols - 1) << fb) ||
            ds < 0 || ds > (longint'(rows - 1) << fb)) begin
            return 1'b0;
        end
        col = int'(cs >> fb);
        row = int'(ds >> fb);
        if (col > cols - 2) begin
            col = cols - 2;
        end
        if (row > rows - 2) begin
            row = rows - 2;
        end
        s = cs - (longint'(col) << fb);
        t = ds - (longint'(row) << fb);
        return 1'b1;
    endfunction

    function automatic longint corner_height(int unsigned index);
        return longint'($signed(height_mem[16'(index)]));
    endfunction

    function automatic t_out_item predict_height(t_in_item it);
        t_out_item   r;
        int unsigned col;
        int unsigned row;
        int unsigned fb;
        int unsigned cols;
        int unsigned base;
        longint      s;
        longint      t;
        longint      one;
        longint      a;
        longint      b;
        longint      c;
        longint      d;
        longint      num;
        longint      h;
        r = '0;
        if (it.req_type == REQ_WRITE) begin
            height_mem[it.entry_index]     = it.entry_height;
            entry_written[it.entry_index] = 1'b1;
            return r;
        end
        if (!find_cell(it.query_x, it.query_z, col, row, s, t, fb)) begin
            r.outside_grid = 1'b1;
            return r;
        end
        cols = clamp_dimension(cfg_columns);
        base = row * cols + col;
        one  = longint'(1) << fb;
        a = corner_height(base);
        b = corner_height(base + 1);
        c = corner_height(base + cols);
        d = corner_height(base + cols + 1);
        if (s + t <= one) begin
            num = a * one + s * (b - a) + t * (c - a);
        end else begin
            num = d * one + (one - s) * (c - d) + (one - t) * (b - d);
        end
        h = (num + (one >>> 1)) >>> fb;
        if (h > 32767) begin
            h = 32767;
        end
        if (h < -32768) begin
            h = -32768;
        end
        r.height_out = 16'(h);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_heights.size() == 0) begin
                $error("result item with no expected result: height_out %0d, outside_grid %0d",
                       o_out_item.height_out, o_out_item.outside_grid);
                error_count++;
            end else begin
                want = pending_heights.pop_front();
                if (o_out_item.height_out !== want.height_out) begin
                    $error("height_out mismatch: expected %0d, got %0d",
                           want.height_out, o_out_item.height_out);
                    error_count++;
                end
                if (o_out_item.outside_grid !== want.outside_grid) begin
                    $error("outside_grid mismatch: expected %0d, got %0d",
                           want.outside_grid, o_out_item.outside_grid);
                    error_count++;
                end
            end
        end
    end

    initial begin : receiver
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(1, 100) <= stall_pct) begin
                    stall_left = $urandom_range(1, 5);
                end
            end
        end
    end

    task automatic send_item(input t_in_item it);
        if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pending_heights.push_back(predict_height(it));
    endtask

    function automatic t_in_item random_payload();
        t_in_item it;
        it.req_type     = 1'($urandom);
        it.entry_index  = 16'($urandom);
        it.entry_height = 16'($urandom);
        it.query_x      = 20'($urandom);
        it.query_z      = 20'($urandom);
        return it;
    endfunction

    task automatic send_write(input logic [IDX_W-1:0] index, input logic [HGT_W-1:0] height);
        t_in_item it;
        it              = random_payload();
        it.req_type     = REQ_WRITE;
        it.entry_index  = index;
        it.entry_height = height;
        send_item(it);
    endtask

    // Corners of the target cell that were never written get a random height
    // first, so a query never reads an undefined entry.
    task automatic query_point(input int x, input int z);
        t_in_item    it;
        int unsigned col;
        int unsigned row;
        int unsigned fb;
        int unsigned cols;
        int unsigned base;
        int unsigned corners [4];
        longint      s;
        longint      t;
        if (find_cell(CRD_W'(x), CRD_W'(z), col, row, s, t, fb)) begin
            cols    = clamp_dimension(cfg_columns);
            base    = row * cols + col;
            corners = '{base, base + 1, base + cols, base + cols + 1};
            foreach (corners[k]) begin
                if (!entry_written[16'(corners[k])]) begin
                    send_write(16'(corners[k]), 16'($urandom));
                end
            end
        end
        it          = random_payload();
        it.req_type = REQ_QUERY;
        it.query_x  = CRD_W'(x);
        it.query_z  = CRD_W'(z);
        send_item(it);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_heights.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] reg_id, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] stored;
        stored  = '0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_id, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        unique case (reg_id)
            REG_GRID_COLUMNS: begin
                cfg_columns = value[DIM_W-1:0];
                stored      = PDATA_W'(value[DIM_W-1:0]);
            end
            REG_GRID_ROWS: begin
                cfg_rows = value[DIM_W-1:0];
                stored   = PDATA_W'(value[DIM_W-1:0]);
            end
            REG_CELL_SPACING_LOG2: begin
                cfg_spacing = value[2:0];
                stored      = PDATA_W'(value[2:0]);
            end
            default: begin
            end
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== stored) begin
            $error("register %0d readback mismatch: expected %0d, got %0d",
                   reg_id, stored, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_grid(input int unsigned cols, input int unsigned rows,
                            input int unsigned spacing);
        drain_results();
        write_register(REG_GRID_COLUMNS, PDATA_W'(cols));
        write_register(REG_GRID_ROWS, PDATA_W'(rows));
        write_register(REG_CELL_SPACING_LOG2, PDATA_W'(spacing));
    endtask

    function automatic int half_extent(int unsigned n);
        longint r;
        if (n < 2) begin
            return 0;
        end
        r = longint'(n - 1) << (7 + cfg_spacing);
        return (r > 524287) ? 524287 : int'(r);
    endfunction

    function automatic int inside_coord(int r);
        unique case ($urandom_range(0, 9))
            0: return r;
            1: return -r;
            default: return int'($urandom_range(0, 2 * r)) - r;
        endcase
    endfunction

    function automatic int outside_coord(int r);
        int v;
        v = r + int'($urandom_range(1, 512));
        if (v > 524287) begin
            return int'($signed(20'($urandom)));
        end
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    task automatic random_item();
        int          pick;
        int          xr;
        int          zr;
        int unsigned span;
        pick = $urandom_range(0, 99);
        xr   = half_extent(clamp_dimension(cfg_columns));
        zr   = half_extent(clamp_dimension(cfg_rows));
        span = clamp_dimension(cfg_columns) * clamp_dimension(cfg_rows);
        if (span == 0) begin
            span = 1;
        end
        if (pick < 12) begin
            send_write(16'($urandom), 16'($urandom));
        end else if (pick < 25) begin
            send_write(16'($urandom_range(0, span - 1)), 16'($urandom));
        end else if (pick < 85) begin
            query_point(inside_coord(xr), inside_coord(zr));
        end else if (pick < 90) begin
            query_point(outside_coord(xr), inside_coord(zr));
        end else if (pick < 95) begin
            query_point(inside_coord(xr), outside_coord(zr));
        end else begin
            query_point(int'($signed(20'($urandom))), int'($signed(20'($urandom))));
        end
    endtask

    task automatic random_items(input int count);
        repeat (count) random_item();
    endtask

    // Reset grid: 256 x 256 points, 255 x 255 cells of one world unit, so the grid spans
    // +-32640 in coordinate units.
    task automatic test_directed_cases();
        send_write(16'h0000, 16'h8000);
        send_write(16'hFFFF, 16'h7FFF);
        query_point(-32640, 32640);
        query_point(32640, -32640);
        query_point(0, 0);
        query_point(-64, 64);
        query_point(64, -64);
        query_point(-128, -128);
        query_point(-32641, 0);
        query_point(32641, 0);
        query_point(0, 32641);
        query_point(0, -32641);
        query_point(-524288, 524287);
        query_point(524287, -524288);
    endtask

    task automatic test_register_settings();
        int unsigned col_set [9]     = '{2, 256, 2, 256, 5, 1, 8, 300, 17};
        int unsigned row_set [9]     = '{2, 256, 256, 2, 3, 8, 0, 511, 9};
        int unsigned spacing_set [9] = '{0, 7, 3, 5, 1, 0, 2, 4, 6};
        foreach (col_set[p]) begin
            gap_pct   = (p % 3 == 1) ? 0 : 25;
            stall_pct = (p % 3 == 2) ? 0 : 25;
            set_grid(col_set[p], row_set[p], spacing_set[p]);
            random_items(30);
        end
    endtask

    task automatic test_output_backpressure();
        set_grid(16, 16, 2);
        gap_pct     = 0;
        stall_pct   = 0;
        hold_cycles = 300;
        random_items(30);
        drain_results();
    endtask

    task automatic test_full_rate();
        set_grid(256, 256, 0);
        gap_pct   = 0;
        stall_pct = 0;
        random_items(40);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cfg_columns = 9'd256;
        cfg_rows    = 9'd256;
        cfg_spacing = 3'd0;
        error_count = 0;
        gap_pct     = 20;
        stall_pct   = 20;
        hold_cycles = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_register_settings();
        test_output_backpressure();
        test_full_rate();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### heightmap_height_query.f
src/hhq_pkg.sv
src/hhq_cfg.sv
src/hhq_store.sv
src/hhq_interp.sv
src/heightmap_height_query.sv
bench/heightmap_height_query_test.sv
